>>> src/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define FQIR_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also covers the reset cycles.
`define FQIR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> src/fqir_pkg.sv
// Package: sizes, codes and shared types of the indexed-removal queue.
package fqir_pkg;

  // Storage geometry (DEPTH must be a power of two: slots wrap by truncation)
  localparam int DEPTH      = 16;
  localparam int ITEM_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IDX_W      = CNT_W + 1;

  // Transaction field widths
  localparam int MODE_W     = 2;
  localparam int ITEM_F_W   = 32;
  localparam int POS_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 5;
  localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Bus widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = ((ITEM_F_W + POS_W + 7) / 8) * 8;
  localparam int IN_PAD_W    = IN_TDATA_W - ITEM_F_W - POS_W;
  localparam int OUT_TDATA_W = ((STATUS_W + ITEM_F_W + OCC_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - STATUS_W - ITEM_F_W - OCC_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ    = 2'd0,
    MODE_DEQ    = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_RESP
  } ctrl_state_t;

  // One response of the queue
  typedef struct packed {
    status_t               status;
    logic [ITEM_F_W-1:0]   item;
    logic [OCC_W-1:0]      occupancy;
  } result_t;

  // Request to the storage RAM
  typedef struct packed {
    logic                  we;
    logic [PTR_W-1:0]      waddr;
    logic [ITEM_WIDTH-1:0] wdata;
    logic                  re;
    logic [PTR_W-1:0]      raddr;
  } mem_req_t;

  // Physical slot of a position counted from the head
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                               input logic [PTR_W-1:0] ofs);
    slot_of = head + ofs;
  endfunction

endpackage

>>> src/fqir_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module fqir_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH_P)-1:0] waddr,
  input  logic [WIDTH_P-1:0]         wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH_P)-1:0] raddr,
  output logic [WIDTH_P-1:0]         rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/fqir_ctrl.sv
// Queue sequencer: head/count registers, RAM accesses and gap compaction.
module fqir_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fqir_pkg::mode_t                     in_mode,
  input  logic [fqir_pkg::ITEM_F_W-1:0]       in_item,
  input  logic [fqir_pkg::POS_W-1:0]          in_position,
  output logic                                res_valid,
  input  logic                                res_ready,
  output fqir_pkg::result_t                   res,
  output fqir_pkg::mem_req_t                  mem_req,
  input  logic [fqir_pkg::ITEM_WIDTH-1:0]     mem_rdata
);
  import fqir_pkg::*;

  ctrl_state_t          state_r, state_nxt;
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [PTR_W-1:0]     k_r, k_nxt;
  mode_t                mode_r, mode_nxt;
  status_t              status_r, status_nxt;
  logic [ITEM_F_W-1:0]  item_r, item_nxt;
  logic [POS_W-1:0]     eff_pos;
  logic                 out_of_range;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Per-transaction working registers
  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    mode_r   <= mode_nxt;
    status_r <= status_nxt;
    item_r   <= item_nxt;
  end

  // Dequeue always addresses the head
  assign eff_pos      = (in_mode == MODE_DEQ) ? '0 : in_position;
  assign out_of_range = CMP_W'(eff_pos) >= CMP_W'(count_r);

  // Next state, RAM requests and response
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    mode_nxt      = mode_r;
    status_nxt    = status_r;
    item_nxt      = item_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = slot_of(head_r, k_r);
    mem_req.wdata = mem_rdata;
    mem_req.re    = 1'b0;
    mem_req.raddr = slot_of(head_r, k_r);
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt = in_mode;
          item_nxt = '0;
          if (in_mode == MODE_ENQ) begin
            if (count_r == CNT_W'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.waddr = slot_of(head_r, PTR_W'(count_r));
              mem_req.wdata = in_item[ITEM_WIDTH-1:0];
              count_nxt     = count_r + CNT_W'(1);
              status_nxt    = ST_OK;
            end
            state_nxt = S_RESP;
          end else if (out_of_range) begin
            status_nxt = ST_RANGE;
            state_nxt  = S_RESP;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = slot_of(head_r, PTR_W'(eff_pos));
            k_nxt         = PTR_W'(eff_pos);
            status_nxt    = ST_OK;
            state_nxt     = S_READ;
          end
        end
      end
      S_READ: begin
        // Target entry arrives; start compaction when removing inside the queue
        item_nxt = ITEM_F_W'(mem_rdata);
        if (mode_r == MODE_PEEK) begin
          state_nxt = S_RESP;
        end else if (k_r == '0) begin
          head_nxt  = head_r + PTR_W'(1);
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_RESP;
        end else if (IDX_W'(k_r) + IDX_W'(1) < IDX_W'(count_r)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = slot_of(head_r, k_r + PTR_W'(1));
          state_nxt     = S_SHIFT;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_RESP;
        end
      end
      S_SHIFT: begin
        // Entry k+1 moves down into slot k; fetch k+2 meanwhile
        mem_req.we = 1'b1;
        k_nxt      = k_r + PTR_W'(1);
        if (IDX_W'(k_r) + IDX_W'(2) < IDX_W'(count_r)) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = slot_of(head_r, k_r + PTR_W'(2));
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.status    = status_r;
  assign res.item      = item_r;
  assign res.occupancy = OCC_W'(count_r);

endmodule

>>> src/fifo_queue_indexed_removal.sv
// Top level of the ordered queue with indexed peek and removal.
//
// Input channel (in_*): one request per transaction. in_tuser carries the
// mode (enqueue, dequeue head, peek at position, remove at position);
// in_tdata carries the item word and the position counted from the head.
// Output channel (out_*): exactly one response per request, in order,
// holding a status, the item returned and the occupancy after the request.
// Requests are handled one at a time. Enqueue, and any request refused
// for range or fullness, goes from acceptance straight to the response
// state; dequeue and peek first pass through a RAM read state. Removal
// inside the queue closes the gap one entry per cycle through the single
// RAM read/write port pair. A new request is taken while the last response
// still waits in the output register. If the receiver stalls, the finished
// response is held in the sequencer and the input stays not ready.
// Reset empties the queue (head and count to zero) and drops any response;
// the storage RAM is not cleared and needs no clearing pass.
`include "assert_macros.svh"

module fifo_queue_indexed_removal (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [fqir_pkg::IN_TDATA_W-1:0]      in_tdata,  // item_in, position, zero pad
  input  logic [fqir_pkg::MODE_W-1:0]          in_tuser,  // mode
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [fqir_pkg::OUT_TDATA_W-1:0]     out_tdata  // status, item_out, occupancy, pad
);
  import fqir_pkg::*;

  logic                  res_valid;
  logic                  res_ready;
  result_t               res;
  mem_req_t              mem_req;
  logic [ITEM_WIDTH-1:0] mem_rdata;
  logic                  out_valid_r, out_valid_nxt;
  result_t               out_q_r;

  fqir_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_mode     (mode_t'(in_tuser)),
    .in_item     (in_tdata[ITEM_F_W-1:0]),
    .in_position (in_tdata[ITEM_F_W+POS_W-1:ITEM_F_W]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata)
  );

  fqir_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (ITEM_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // Output register
  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_q_r.occupancy, out_q_r.item, out_q_r.status};

  // Checks
  `FQIR_ASSERT_CLK(a_busy_after_accept,
    in_tvalid && in_tready |=> !in_tready,
    "request taken while busy")
  `FQIR_ASSERT_CLK(a_full_at_depth,
    out_tvalid && out_q_r.status == ST_FULL |-> out_q_r.occupancy == OCC_W'(DEPTH),
    "full status below depth")
  `FQIR_ASSERT_CLK(a_refused_no_item,
    out_tvalid && out_q_r.status != ST_OK |-> out_q_r.item == '0,
    "refused request returned an item")
  `FQIR_ASSERT_ALWAYS(a_reset_drops_resp,
    !rst_n |=> !out_tvalid,
    "response survived reset")

endmodule
